@@ hdl/tcon_pkg.sv @@
// Package for the telnet client option negotiator.
// Holds telnet byte codes, the reply burst kinds and the burst byte tables.
// No dependencies.
package tcon_pkg;

   // Telnet command bytes
   localparam logic [7:0] B_IAC  = 8'd255;
   localparam logic [7:0] B_DONT = 8'd254;
   localparam logic [7:0] B_DO   = 8'd253;
   localparam logic [7:0] B_WONT = 8'd252;
   localparam logic [7:0] B_WILL = 8'd251;
   localparam logic [7:0] B_SB   = 8'd250;
   localparam logic [7:0] B_SE   = 8'd240;

   // Option codes
   localparam logic [7:0] OPT_ECHO = 8'd1;
   localparam logic [7:0] OPT_SUPP = 8'd3;
   localparam logic [7:0] OPT_TERM = 8'd24;

   // Terminal-type subnegotiation codes
   localparam logic [7:0] TTYPE_IS   = 8'd0;
   localparam logic [7:0] TTYPE_SEND = 8'd1;

   // Burst index width: longest burst is ten bytes
   localparam int IDX_W = 4;

   typedef enum logic [2:0] {
      K_FWD,       // one data byte to the user side
      K_CMD,       // IAC <cmd> <opt>
      K_SGA_ON,    // IAC DO 3, IAC WILL 3, IAC DO 1
      K_SGA_OFF,   // IAC DONT 3, IAC WONT 3
      K_TT_NVT,    // IAC SB 24 IS N V T IAC SE
      K_TT_ANSI    // IAC SB 24 IS A N S I IAC SE
   } burst_kind_type;

   // One burst of results caused by one accepted transaction
   typedef struct packed {
      logic           load;
      burst_kind_type kind;
      logic [7:0]     arg;
      logic [7:0]     opt;
   } burst_type;

   // Number of bytes in a burst
   function automatic logic [IDX_W-1:0] burst_len(input burst_kind_type kind);
      logic [IDX_W-1:0] len;
      unique case (kind)
         K_FWD:     len = IDX_W'(1);
         K_CMD:     len = IDX_W'(3);
         K_SGA_ON:  len = IDX_W'(9);
         K_SGA_OFF: len = IDX_W'(6);
         K_TT_NVT:  len = IDX_W'(9);
         K_TT_ANSI: len = IDX_W'(10);
         default:   len = IDX_W'(1);
      endcase
      return len;
   endfunction

   // Byte at position idx of a burst
   function automatic logic [7:0] burst_byte(input burst_kind_type kind,
                                             input logic [7:0] arg,
                                             input logic [7:0] opt,
                                             input logic [IDX_W-1:0] idx);
      logic [7:0] b;
      b = B_IAC;
      unique case (kind)
         K_FWD: b = arg;
         K_CMD: begin
            unique case (idx)
               IDX_W'(1): b = arg;
               IDX_W'(2): b = opt;
               default:   b = B_IAC;
            endcase
         end
         K_SGA_ON: begin
            unique case (idx)
               IDX_W'(1): b = B_DO;
               IDX_W'(2): b = OPT_SUPP;
               IDX_W'(4): b = B_WILL;
               IDX_W'(5): b = OPT_SUPP;
               IDX_W'(7): b = B_DO;
               IDX_W'(8): b = OPT_ECHO;
               default:   b = B_IAC;
            endcase
         end
         K_SGA_OFF: begin
            unique case (idx)
               IDX_W'(1): b = B_DONT;
               IDX_W'(2): b = OPT_SUPP;
               IDX_W'(4): b = B_WONT;
               IDX_W'(5): b = OPT_SUPP;
               default:   b = B_IAC;
            endcase
         end
         K_TT_NVT: begin
            unique case (idx)
               IDX_W'(1): b = B_SB;
               IDX_W'(2): b = OPT_TERM;
               IDX_W'(3): b = TTYPE_IS;
               IDX_W'(4): b = 8'h4E;   // N
               IDX_W'(5): b = 8'h56;   // V
               IDX_W'(6): b = 8'h54;   // T
               IDX_W'(8): b = B_SE;
               default:   b = B_IAC;
            endcase
         end
         K_TT_ANSI: begin
            unique case (idx)
               IDX_W'(1): b = B_SB;
               IDX_W'(2): b = OPT_TERM;
               IDX_W'(3): b = TTYPE_IS;
               IDX_W'(4): b = 8'h41;   // A
               IDX_W'(5): b = 8'h4E;   // N
               IDX_W'(6): b = 8'h53;   // S
               IDX_W'(7): b = 8'h49;   // I
               IDX_W'(9): b = B_SE;
               default:   b = B_IAC;
            endcase
         end
         default: b = B_IAC;
      endcase
      return b;
   endfunction

endpackage

@@ hdl/tcon_if.sv @@
// Valid/ready channel interfaces for the telnet option negotiator.
// Request carries one received byte; response carries one emitted byte.
// No dependencies.
interface tcon_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tcon_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       to_host;
   logic       last;

   modport source (output valid, output out_byte, output to_host, output last,
                   input ready);
   modport sink   (input valid, input out_byte, input to_host, input last,
                   output ready);
endinterface

@@ hdl/tcon_decode.sv @@
// Telnet parser state and option decision logic.
// Updates parser/option state per accepted transaction and describes the reply burst.
// Depends on tcon_pkg.
module tcon_decode
   import tcon_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   output burst_type  burst
);

   typedef enum logic [1:0] {
      PH_DATA,
      PH_CODE,
      PH_OPT
   } phase_type;

   typedef enum logic [2:0] {
      V_SB,
      V_WILL,
      V_WONT,
      V_DO,
      V_DONT
   } verb_type;

   typedef enum logic [1:0] {
      SINK_USER,
      SINK_DROP,
      SINK_TERM
   } sink_type;

   phase_type  phase_ff, phase_in;
   verb_type   verb_ff, verb_in;
   sink_type   sink_ff, sink_in;
   logic       echo_ff, echo_in;
   logic       char_ff, char_in;
   logic [1:0] term_ff, term_in;
   logic       to_sink;

   // Next state and reply burst for the byte on the request channel
   always_comb begin
      phase_in     = PH_DATA;
      verb_in      = verb_ff;
      sink_in      = sink_ff;
      echo_in      = echo_ff;
      char_in      = char_ff;
      term_in      = term_ff;
      to_sink      = 1'b0;
      burst.load   = 1'b0;
      burst.kind   = K_FWD;
      burst.arg    = rx_byte;
      burst.opt    = rx_byte;

      unique case (phase_ff)
         PH_CODE: begin
            unique case (rx_byte)
               B_IAC:  to_sink = 1'b1;
               B_SE:   sink_in = SINK_USER;
               B_SB:   begin verb_in = V_SB;   phase_in = PH_OPT; end
               B_WILL: begin verb_in = V_WILL; phase_in = PH_OPT; end
               B_WONT: begin verb_in = V_WONT; phase_in = PH_OPT; end
               B_DO:   begin verb_in = V_DO;   phase_in = PH_OPT; end
               B_DONT: begin verb_in = V_DONT; phase_in = PH_OPT; end
               default: ;
            endcase
         end
         PH_OPT: begin
            if (verb_ff != V_WILL && verb_ff != V_WONT &&
                verb_ff != V_DO && verb_ff != V_DONT) begin
               // subnegotiation start: only terminal type has a handler
               sink_in = (rx_byte == OPT_TERM) ? SINK_TERM : SINK_DROP;
            end else if (rx_byte == OPT_ECHO) begin
               if (verb_ff == V_WILL) begin
                  if (!echo_ff) begin
                     echo_in = 1'b1;
                     burst.load = 1'b1; burst.kind = K_CMD; burst.arg = B_DO;
                  end
               end else if (verb_ff == V_WONT) begin
                  if (echo_ff) begin
                     echo_in = 1'b0;
                     burst.load = 1'b1; burst.kind = K_CMD; burst.arg = B_DONT;
                  end
               end else begin
                  burst.load = 1'b1; burst.kind = K_CMD; burst.arg = B_WONT;
               end
            end else if (rx_byte == OPT_SUPP) begin
               if (verb_ff == V_WILL) begin
                  if (!char_ff) begin
                     char_in = 1'b1;
                     echo_in = 1'b1;
                     burst.load = 1'b1; burst.kind = K_SGA_ON;
                  end
               end else if (verb_ff == V_WONT) begin
                  if (char_ff) begin
                     char_in = 1'b0;
                     burst.load = 1'b1; burst.kind = K_SGA_OFF;
                  end
               end else if (verb_ff == V_DO) begin
                  if (!char_ff) begin
                     burst.load = 1'b1; burst.kind = K_CMD; burst.arg = B_DO;
                  end
               end else begin
                  if (char_ff) begin
                     burst.load = 1'b1; burst.kind = K_CMD; burst.arg = B_DONT;
                  end
               end
            end else begin
               // terminal type and refused options both answer WILL with DONT; DO gets WILL only for terminal type
               if (verb_ff == V_WILL) begin
                  burst.load = 1'b1; burst.kind = K_CMD; burst.arg = B_DONT;
               end else if (verb_ff == V_DO) begin
                  burst.load = 1'b1; burst.kind = K_CMD;
                  burst.arg = (rx_byte == OPT_TERM) ? B_WILL : B_WONT;
               end
            end
         end
         default: begin
            if (rx_byte == B_IAC) phase_in = PH_CODE;
            else                  to_sink  = 1'b1;
         end
      endcase

      // Data byte routed through the current sink
      if (to_sink) begin
         if (sink_ff == SINK_USER) begin
            burst.load = 1'b1;
            burst.kind = K_FWD;
         end else if (sink_ff == SINK_TERM && rx_byte == TTYPE_SEND) begin
            term_in    = (term_ff >= 2'd2) ? 2'd0 : term_ff + 2'd1;
            burst.load = 1'b1;
            burst.kind = (term_in == 2'd0) ? K_TT_NVT : K_TT_ANSI;
         end
      end
   end

   // State registers, updated once per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DATA;
         verb_ff  <= V_SB;
         sink_ff  <= SINK_USER;
         echo_ff  <= 1'b0;
         char_ff  <= 1'b0;
         term_ff  <= 2'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         verb_ff  <= verb_in;
         sink_ff  <= sink_in;
         echo_ff  <= echo_in;
         char_ff  <= char_in;
         term_ff  <= term_in;
      end
   end

endmodule

@@ hdl/tcon_emit.sv @@
// Result register and burst sequencer for the telnet option negotiator.
// Holds one reply burst and steps through its bytes on the response channel.
// Depends on tcon_pkg and tcon_rsp_if.
module tcon_emit
   import tcon_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  burst_type         burst,
   output logic              take_ok,
   tcon_rsp_if.source        rsp_chan
);

   logic             busy_ff;
   burst_kind_type   kind_ff;
   logic [7:0]       arg_ff;
   logic [7:0]       opt_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             at_last;
   logic             done;

   assign at_last = (idx_ff == burst_len(kind_ff) - IDX_W'(1));
   assign done    = rsp_chan.valid && rsp_chan.ready && at_last;

   // Next request may enter when the burst is empty or finishing now
   assign take_ok = !busy_ff || done;

   assign rsp_chan.valid    = busy_ff;
   assign rsp_chan.out_byte = burst_byte(kind_ff, arg_ff, opt_ff, idx_ff);
   assign rsp_chan.to_host  = (kind_ff != K_FWD);
   assign rsp_chan.last     = at_last;

   // Burst control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (accept && burst.load) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (done) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         idx_ff  <= idx_ff + IDX_W'(1);
      end
   end

   // Burst payload
   always_ff @(posedge clock) begin
      if (accept && burst.load) begin
         kind_ff <= burst.kind;
         arg_ff  <= burst.arg;
         opt_ff  <= burst.opt;
      end
   end

endmodule

@@ hdl/telnet_client_option_negotiator_core.sv @@
// Telnet client option negotiator: parses received bytes, forwards data, answers options.
// The first result is registered and appears in the cycle after the request is accepted.
// Data moves one byte per cycle while rsp_chan is ready; a reply burst is 3 to 10 bytes,
// and the next request is taken in the cycle the burst's last byte is accepted.
// Reset (synchronous, active high): data phase, forward sink, all flags and counter cleared.
module telnet_client_option_negotiator_core
   import tcon_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tcon_req_if.sink    req_chan,
   tcon_rsp_if.source  rsp_chan
);

   burst_type burst;
   logic      take_ok;
   logic      accept;

   assign req_chan.ready = take_ok;
   assign accept         = req_chan.valid && take_ok;

   // Parser and option state
   tcon_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_chan.rx_byte),
      .burst   (burst)
   );

   // Result register and reply sequencer
   tcon_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .burst    (burst),
      .take_ok  (take_ok),
      .rsp_chan (rsp_chan)
   );

endmodule
